[hw/rtl/gbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gbt_pkg;

    // default fixed point scale, fraction bits per degree
    localparam int ANGLE_FRAC_BITS_DEF = 20;

    // field widths
    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int BOUND_W = 29;
    localparam int RECT_W  = 31;

    // tracked edges hold an input or a 1000 degree sentinel (up to 21 fraction bits)
    localparam int EDGE_W = 32;
    // room for edge differences and the 360 degree correction
    localparam int CALC_W = 34;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_BOTTOM = 2'd3;

    // input word kinds
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [EDGE_W-1:0] north;
        logic signed [EDGE_W-1:0] south;
        logic signed [EDGE_W-1:0] plain_west;
        logic signed [EDGE_W-1:0] plain_east;
        logic signed [EDGE_W-1:0] dateline_west;
        logic signed [EDGE_W-1:0] dateline_east;
    } edges_t;

    typedef struct packed {
        logic [RECT_W-1:0] left;
        logic [RECT_W-1:0] right;
        logic [RECT_W-1:0] top;
        logic [RECT_W-1:0] bottom;
        logic              explicit_used;
        logic              wraps;
    } rect_t;

endpackage

`default_nettype wire

[hw/rtl/gbt_edge_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbt_edge_tracker #(
    parameter int ANGLE_FRAC_BITS = gbt_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                upd,
    input  wire                                op,
    input  wire logic signed [gbt_pkg::LAT_W-1:0] latitude,
    input  wire logic signed [gbt_pkg::LON_W-1:0] longitude,
    output gbt_pkg::edges_t                    edges_next
);

    localparam longint ONE_DEG = longint'(1) << ANGLE_FRAC_BITS;
    localparam logic signed [gbt_pkg::EDGE_W-1:0] SENT_POS =
        gbt_pkg::EDGE_W'(1000 * ONE_DEG);
    localparam logic signed [gbt_pkg::EDGE_W-1:0] SENT_NEG =
        gbt_pkg::EDGE_W'(-1000 * ONE_DEG);

    gbt_pkg::edges_t edges_reg;
    gbt_pkg::edges_t edges_clear;
    logic signed [gbt_pkg::EDGE_W-1:0] lat_ext;
    logic signed [gbt_pkg::EDGE_W-1:0] lon_ext;

    // sentinel edges of an empty tracker
    always_comb
    begin
        edges_clear.north         = SENT_NEG;
        edges_clear.south         = SENT_POS;
        edges_clear.plain_west    = SENT_POS;
        edges_clear.plain_east    = SENT_NEG;
        edges_clear.dateline_west = SENT_POS;
        edges_clear.dateline_east = SENT_NEG;
    end

    assign lat_ext = gbt_pkg::EDGE_W'(latitude);
    assign lon_ext = gbt_pkg::EDGE_W'(longitude);

    // widen the edges with the point, or go back to sentinels on clear
    always_comb
    begin
        edges_next = edges_reg;
        if (op == gbt_pkg::OP_CLEAR)
        begin
            edges_next = edges_clear;
        end
        else
        begin
            if (lat_ext > edges_reg.north)
                edges_next.north = lat_ext;
            if (lat_ext < edges_reg.south)
                edges_next.south = lat_ext;
            if (lon_ext < edges_reg.plain_west)
                edges_next.plain_west = lon_ext;
            if (lon_ext > edges_reg.plain_east)
                edges_next.plain_east = lon_ext;
            // dateline pair: west takes eastern longitudes, east takes western ones
            if (lon_ext < edges_reg.dateline_west && lon_ext > 0)
                edges_next.dateline_west = lon_ext;
            if (lon_ext > edges_reg.dateline_east && lon_ext <= 0)
                edges_next.dateline_east = lon_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_reg <= edges_clear;
        end
        else if (upd)
        begin
            edges_reg <= edges_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gbt_rect_select.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbt_rect_select #(
    parameter int ANGLE_FRAC_BITS = gbt_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire gbt_pkg::edges_t                     edges,
    input  wire logic signed [gbt_pkg::BOUND_W-1:0]  bound_left,
    input  wire logic signed [gbt_pkg::BOUND_W-1:0]  bound_right,
    input  wire logic signed [gbt_pkg::BOUND_W-1:0]  bound_top,
    input  wire logic signed [gbt_pkg::BOUND_W-1:0]  bound_bottom,
    output gbt_pkg::rect_t                           rect
);

    localparam int W = gbt_pkg::CALC_W;
    localparam longint ONE_DEG = longint'(1) << ANGLE_FRAC_BITS;
    localparam logic signed [W-1:0] DEG_90  = W'(90 * ONE_DEG);
    localparam logic signed [W-1:0] DEG_180 = W'(180 * ONE_DEG);
    localparam logic signed [W-1:0] DEG_360 = W'(360 * ONE_DEG);

    logic signed [W-1:0] bl, br, bt, bb;
    logic signed [W-1:0] dw, de, pw, pe;
    logic signed [W-1:0] dl_span, pl_span;
    logic signed [W-1:0] l, r, t, b, r_adj;
    logic                bound_ok;

    assign bl = W'(bound_left);
    assign br = W'(bound_right);
    assign bt = W'(bound_top);
    assign bb = W'(bound_bottom);

    assign dw = W'(edges.dateline_west);
    assign de = W'(edges.dateline_east);
    assign pw = W'(edges.plain_west);
    assign pe = W'(edges.plain_east);

    // explicit bound validity checks
    always_comb
    begin
        bound_ok = 1'b1;
        if (br == bl || bb == bt)
            bound_ok = 1'b0;
        if (bb > DEG_90 || bb < -DEG_90 || bt > DEG_90 || bt < -DEG_90 || bb > bt)
            bound_ok = 1'b0;
        if (bl >= DEG_180 || bl <= -DEG_180 || br > DEG_180 || br < -DEG_180)
            bound_ok = 1'b0;
    end

    assign dl_span = dw - de;
    assign pl_span = pe - pw;

    // pick explicit bound or the narrower auto rectangle
    always_comb
    begin
        if (bound_ok)
        begin
            l = bl;
            r = br;
            t = bt;
            b = bb;
        end
        else
        begin
            t = W'(edges.north);
            b = W'(edges.south);
            if (dl_span < pl_span)
            begin
                l = dw;
                r = de;
            end
            else
            begin
                l = pw;
                r = pe;
            end
        end
    end

    // east edge left of west edge wraps by a full turn
    assign r_adj = (r < l) ? (r + DEG_360) : r;

    assign rect.left          = l[gbt_pkg::RECT_W-1:0];
    assign rect.right         = r_adj[gbt_pkg::RECT_W-1:0];
    assign rect.top           = t[gbt_pkg::RECT_W-1:0];
    assign rect.bottom        = b[gbt_pkg::RECT_W-1:0];
    assign rect.explicit_used = bound_ok;
    assign rect.wraps         = (r_adj > DEG_180);

endmodule

`default_nettype wire

[hw/rtl/geo_bounding_box_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Map point bounding box tracker.
// Slave stream: s_tdata carries a point (latitude, longitude), s_tuser the kind:
// add a point, or clear all tracked edges back to their sentinels.
// Master stream: one word per input word, the normalized display rectangle
// with flags for an explicit bound in use and an east edge past 180 degrees.
// The config port writes the explicit bound edges; write it only while idle.
// A word accepted from the slave side sits in the input register, moves into
// the result register once that register can take it, and shows on the master
// side from then on. Throughput: one word per cycle while the receiver does
// not stall; the edge compare and rectangle select sit in one
// register-to-register path, and edge state updates with the result.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word before s_tready drops.
// Reset clears the tracked edges to the +/-1000 degree sentinels, the bound
// registers to zero and both stream stages to empty.
module geo_bounding_box_tracker #(
    parameter int ANGLE_FRAC_BITS = gbt_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // config write port
    input  wire                              cfg_we,
    input  wire [gbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [gbt_pkg::BOUND_W-1:0]       cfg_wdata,
    // input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [63:0]                       s_tdata,  // latitude[27:0], longitude[56:28]
    input  wire [0:0]                        s_tuser,  // op[0]
    // output stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // rect_left[30:0], rect_right[61:31], rect_top[92:62], rect_bottom[123:93]
    output logic [127:0]                     m_tdata,
    // explicit_bound_used[0], wraps_past_180[1]
    output logic [1:0]                       m_tuser
);

    localparam int LAT_W = gbt_pkg::LAT_W;
    localparam int LON_W = gbt_pkg::LON_W;

    logic signed [gbt_pkg::BOUND_W-1:0] bound_left_reg;
    logic signed [gbt_pkg::BOUND_W-1:0] bound_right_reg;
    logic signed [gbt_pkg::BOUND_W-1:0] bound_top_reg;
    logic signed [gbt_pkg::BOUND_W-1:0] bound_bottom_reg;

    logic                    in_valid_reg;
    logic                    op_reg;
    logic signed [LAT_W-1:0] lat_reg;
    logic signed [LON_W-1:0] lon_reg;

    logic                    out_valid_reg;
    gbt_pkg::rect_t          rect_reg;

    logic                    advance;
    logic                    upd;
    gbt_pkg::edges_t         edges_next;
    gbt_pkg::rect_t          rect_next;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_left_reg   <= '0;
            bound_right_reg  <= '0;
            bound_top_reg    <= '0;
            bound_bottom_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gbt_pkg::CFG_BOUND_LEFT:   bound_left_reg   <= cfg_wdata;
                gbt_pkg::CFG_BOUND_RIGHT:  bound_right_reg  <= cfg_wdata;
                gbt_pkg::CFG_BOUND_TOP:    bound_top_reg    <= cfg_wdata;
                gbt_pkg::CFG_BOUND_BOTTOM: bound_bottom_reg <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign upd      = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg  <= s_tuser[0];
            lat_reg <= s_tdata[LAT_W-1:0];
            lon_reg <= s_tdata[LAT_W+LON_W-1:LAT_W];
        end
    end

    gbt_edge_tracker #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .op         (op_reg),
        .latitude   (lat_reg),
        .longitude  (lon_reg),
        .edges_next (edges_next)
    );

    gbt_rect_select #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_select (
        .edges        (edges_next),
        .bound_left   (bound_left_reg),
        .bound_right  (bound_right_reg),
        .bound_top    (bound_top_reg),
        .bound_bottom (bound_bottom_reg),
        .rect         (rect_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            rect_reg <= rect_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, rect_reg.bottom, rect_reg.top, rect_reg.right, rect_reg.left};
    assign m_tuser  = {rect_reg.wraps, rect_reg.explicit_used};

endmodule

`default_nettype wire
